// ===== rtl/assert_macros.svh =====
// Assertion macros for the converter RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ROCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ROCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rocc_pkg.sv =====
// Shared constants, stage types and helpers of the radial offset converter.
// No dependencies; used by radial_offset_coord_convert_top.
package rocc_pkg;

    localparam int CORDIC_STAGES = 20;
    localparam int RED_STEPS     = 13;   // quotient bits of the 2*pi reduction
    localparam int VEC_STEPS     = (CORDIC_STAGES > RED_STEPS) ? CORDIC_STAGES : RED_STEPS;

    localparam int DW   = 40;            // coordinate datapath, Q.17
    localparam int AW   = 36;            // angle datapath, Q.30
    localparam int RW   = 46;            // reduction remainder
    localparam int GL   = 20;            // low slice of the gain multiply
    localparam int PH_W = DW - GL + 31;
    localparam int PL_W = GL + 30;
    localparam int SW   = DW + 32;

    localparam logic [1:0] REG_COORD_MODE    = 2'd0;
    localparam logic [1:0] REG_RADIAL_OFFSET = 2'd1;

    localparam logic signed [AW-1:0] ANG_PI      = 36'sd3373259426;
    localparam logic signed [AW-1:0] ANG_HALF_PI = 36'sd1686629713;
    localparam logic signed [AW-1:0] ANG_TWO_PI  = 36'sd6746518852;
    localparam logic [RW-1:0]        TWO_PI_R    = 46'd6746518852;
    localparam logic signed [30:0]   GAIN_K      = 31'sd652032874;
    localparam logic [29:0]          GAIN_U      = 30'd652032874;
    localparam logic signed [SW-1:0] GAIN_RND    = 72'sd536870912;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [AW-1:0] z;
        logic                 zero;
        logic [RW-1:0]        rem;
        logic                 neg;
        logic                 mode;
        logic signed [DW-1:0] l;
        logic signed [DW-1:0] a;
        logic [31:0]          hz;
    } vec_t;

    typedef struct packed {
        logic signed [PH_W-1:0] ph;
        logic [PL_W-1:0]        pl;
        logic signed [AW-1:0]   m;
        logic signed [AW-1:0]   z;
        logic                   zero;
        logic                   mode;
        logic signed [DW-1:0]   l;
        logic signed [DW-1:0]   a;
        logic [31:0]            hz;
    } g1_t;

    typedef struct packed {
        logic signed [DW-1:0] mag;
        logic signed [AW-1:0] m;
        logic signed [AW-1:0] z;
        logic                 zero;
        logic                 mode;
        logic signed [DW-1:0] l;
        logic signed [DW-1:0] a;
        logic [31:0]          hz;
    } g2_t;

    typedef struct packed {
        logic signed [DW-1:0] r;
        logic signed [AW-1:0] ang;
        logic [31:0]          hz;
    } g3_t;

    typedef struct packed {
        logic signed [PH_W-1:0] ph;
        logic [PL_W-1:0]        pl;
        logic signed [AW-1:0]   ang;
        logic [31:0]            hz;
    } g4_t;

    typedef struct packed {
        logic signed [DW-1:0] gx;
        logic signed [AW-1:0] ang;
        logic [31:0]          hz;
    } g5_t;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [AW-1:0] z;
        logic [31:0]          hz;
    } rot_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } res_t;

    // atan(2^-i) in Q.30, truncated
    function automatic logic signed [AW-1:0] atan_q30(input logic [4:0] i);
        logic signed [AW-1:0] t;
        unique case (i)
            5'd0:    t = 36'sh03243F6A8;
            5'd1:    t = 36'sh01DAC6705;
            5'd2:    t = 36'sh00FADBAFC;
            5'd3:    t = 36'sh007F56EA6;
            5'd4:    t = 36'sh003FEAB76;
            5'd5:    t = 36'sh001FFD55B;
            5'd6:    t = 36'sh000FFFAAA;
            5'd7:    t = 36'sh0007FFF55;
            5'd8:    t = 36'sh0003FFFEA;
            5'd9:    t = 36'sh0001FFFFD;
            5'd10:   t = 36'sh0000FFFFF;
            5'd11:   t = 36'sh00007FFFF;
            5'd12:   t = 36'sh00003FFFF;
            5'd13:   t = 36'sh00001FFFF;
            5'd14:   t = 36'sh00000FFFF;
            5'd15:   t = 36'sh000007FFF;
            5'd16:   t = 36'sh000003FFF;
            5'd17:   t = 36'sh000001FFF;
            5'd18:   t = 36'sh000000FFF;
            5'd19:   t = 36'sh0000007FF;
            5'd20:   t = 36'sh0000003FF;
            5'd21:   t = 36'sh0000001FF;
            5'd22:   t = 36'sh0000000FF;
            5'd23:   t = 36'sh00000007F;
            5'd24:   t = 36'sh00000003F;
            5'd25:   t = 36'sh00000001F;
            5'd26:   t = 36'sh00000000F;
            5'd27:   t = 36'sh000000008;
            5'd28:   t = 36'sh000000004;
            5'd29:   t = 36'sh000000002;
            5'd30:   t = 36'sh000000001;
            default: t = 36'sh000000000;
        endcase
        return t;
    endfunction

    // Q.17 -> Q.16 with round half up, then clamp to 32 bits
    function automatic logic [31:0] to_out(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] s;
        logic [31:0]          o;
        s = (v + DW'(1)) >>> 1;
        if (s > $signed(DW'(32'h7FFFFFFF))) begin
            o = 32'h7FFFFFFF;
        end
        else if (s < -$signed(DW'(33'h080000000))) begin
            o = 32'h80000000;
        end
        else begin
            o = s[31:0];
        end
        return o;
    endfunction

endpackage

// ===== rtl/radial_offset_coord_convert_top.sv =====
// Top level of the radial offset coordinate converter: pipelined CORDIC
// vectoring, 2*pi reduction, gain correction and CORDIC rotation.
// Depends on rocc_pkg and assert_macros.svh.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  input   | in_valid, in_stall, first_coord,           | in
//          | second_coord, height                       |
//  output  | out_valid, out_stall, out_x, out_y, out_z  | out
//  config  | cfg_we, cfg_index, cfg_data                | in
//
// One transfer per cycle sustained while out_stall stays low. All stages move
// together; a two-entry output (register plus skid) keeps the pipe flowing
// while one result waits. in_stall rises only when both are full.
// Reset clears the valid bits and config registers; no clearing pass.

`include "assert_macros.svh"

module radial_offset_coord_convert_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] first_coord,
    input  logic [31:0] second_coord,
    input  logic [31:0] height,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int DW = rocc_pkg::DW;
    localparam int AW = rocc_pkg::AW;
    localparam int RW = rocc_pkg::RW;
    localparam int GL = rocc_pkg::GL;
    localparam int SW = rocc_pkg::SW;
    localparam int NV = rocc_pkg::VEC_STEPS;
    localparam int NR = rocc_pkg::CORDIC_STAGES;
    localparam int NQ = rocc_pkg::RED_STEPS;

    // ---------------- configuration ----------------
    logic        coord_mode_reg;
    logic [31:0] radial_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_mode_reg    <= 1'b0;
            radial_offset_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == rocc_pkg::REG_COORD_MODE)
            begin
                coord_mode_reg <= cfg_data[0];
            end
            else if (cfg_index == rocc_pkg::REG_RADIAL_OFFSET)
            begin
                radial_offset_reg <= cfg_data;
            end
        end
    end

    // ---------------- flow control ----------------
    logic adv;
    logic out_take;
    logic out_vld_reg;
    logic skid_vld_reg;

    logic [NV:0]   vv_reg;   // input stage plus vectoring stages
    logic [4:0]    gv_reg;   // gain / select stages
    logic [NR:0]   rv_reg;   // fold stage plus rotation stages

    assign adv      = ~skid_vld_reg;
    assign in_stall = skid_vld_reg;
    assign out_take = out_vld_reg & ~out_stall;

    // ---------------- input stage ----------------
    rocc_pkg::vec_t vs_reg  [NV+1];
    rocc_pkg::vec_t vs_next [NV+1];

    logic signed [DW-1:0] a0;
    logic signed [DW-1:0] y0;
    logic signed [RW-1:0] bv;

    always_comb
    begin
        a0 = {{(DW-33){first_coord[31]}}, first_coord, 1'b0};
        y0 = {{(DW-33){second_coord[31]}}, second_coord, 1'b0};
        bv = {second_coord, 14'b0};
        vs_next[0].zero = (first_coord == 32'd0) && (second_coord == 32'd0);
        // left half plane: turn by pi first
        if (first_coord[31])
        begin
            vs_next[0].x = -a0;
            vs_next[0].y = -y0;
            vs_next[0].z = second_coord[31] ? -rocc_pkg::ANG_PI : rocc_pkg::ANG_PI;
        end
        else
        begin
            vs_next[0].x = a0;
            vs_next[0].y = y0;
            vs_next[0].z = '0;
        end
        vs_next[0].neg  = second_coord[31];
        vs_next[0].rem  = second_coord[31] ? RW'(-bv) : RW'(bv);
        vs_next[0].mode = coord_mode_reg;
        vs_next[0].l    = {{(DW-33){radial_offset_reg[31]}}, radial_offset_reg, 1'b0};
        vs_next[0].a    = a0;
        vs_next[0].hz   = height;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vs_reg[0] <= vs_next[0];
        end
    end

    // ---------------- vectoring and angle reduction ----------------
    genvar s;
    generate
        for (s = 0; s < NV; s++)
        begin : g_vec
            localparam int SH = s;
            localparam logic [RW-1:0] RCMP = (s < NQ) ? (rocc_pkg::TWO_PI_R << (NQ-1-s)) : '0;
            always_comb
            begin
                vs_next[s+1] = vs_reg[s];
                if (SH < NR)
                begin
                    if (!vs_reg[s].y[DW-1])
                    begin
                        vs_next[s+1].x = vs_reg[s].x + (vs_reg[s].y >>> SH);
                        vs_next[s+1].y = vs_reg[s].y - (vs_reg[s].x >>> SH);
                        vs_next[s+1].z = vs_reg[s].z + rocc_pkg::atan_q30(5'(SH));
                    end
                    else
                    begin
                        vs_next[s+1].x = vs_reg[s].x - (vs_reg[s].y >>> SH);
                        vs_next[s+1].y = vs_reg[s].y + (vs_reg[s].x >>> SH);
                        vs_next[s+1].z = vs_reg[s].z - rocc_pkg::atan_q30(5'(SH));
                    end
                end
                // restoring step of |angle| mod 2*pi, one quotient bit
                if ((SH < NQ) && (vs_reg[s].rem >= RCMP))
                begin
                    vs_next[s+1].rem = vs_reg[s].rem - RCMP;
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    vs_reg[s+1] <= vs_next[s+1];
                end
            end
        end
    endgenerate

    // ---------------- gain on magnitude, signed remainder ----------------
    rocc_pkg::g1_t g1_reg, g1_next;
    rocc_pkg::g2_t g2_reg, g2_next;
    rocc_pkg::g3_t g3_reg, g3_next;
    rocc_pkg::g4_t g4_reg, g4_next;
    rocc_pkg::g5_t g5_reg, g5_next;
    logic signed [AW-1:0] remw;
    logic signed [SW-1:0] sum_mag;
    logic signed [SW-1:0] sum_r;

    always_comb
    begin
        remw          = AW'(vs_reg[NV].rem);
        g1_next.ph    = $signed(vs_reg[NV].x[DW-1:GL]) * rocc_pkg::GAIN_K;
        g1_next.pl    = vs_reg[NV].x[GL-1:0] * rocc_pkg::GAIN_U;
        g1_next.m     = vs_reg[NV].neg ? -remw : remw;
        g1_next.z     = vs_reg[NV].z;
        g1_next.zero  = vs_reg[NV].zero;
        g1_next.mode  = vs_reg[NV].mode;
        g1_next.l     = vs_reg[NV].l;
        g1_next.a     = vs_reg[NV].a;
        g1_next.hz    = vs_reg[NV].hz;
    end

    // sum partial products, round; wrap polar angle into [-pi, pi)
    always_comb
    begin
        sum_mag = (SW'(g1_reg.ph) <<< GL) + $signed(SW'(g1_reg.pl)) + rocc_pkg::GAIN_RND;
        g2_next.mag = DW'(sum_mag >>> 30);
        if (g1_reg.m >= rocc_pkg::ANG_PI)
        begin
            g2_next.m = g1_reg.m - rocc_pkg::ANG_TWO_PI;
        end
        else if (g1_reg.m < -rocc_pkg::ANG_PI)
        begin
            g2_next.m = g1_reg.m + rocc_pkg::ANG_TWO_PI;
        end
        else
        begin
            g2_next.m = g1_reg.m;
        end
        g2_next.z    = g1_reg.z;
        g2_next.zero = g1_reg.zero;
        g2_next.mode = g1_reg.mode;
        g2_next.l    = g1_reg.l;
        g2_next.a    = g1_reg.a;
        g2_next.hz   = g1_reg.hz;
    end

    // radius and angle per mode; the origin gives angle zero
    always_comb
    begin
        g3_next.r   = g2_reg.l - (g2_reg.mode ? g2_reg.a : g2_reg.mag);
        g3_next.ang = g2_reg.mode ? g2_reg.m : (g2_reg.zero ? '0 : g2_reg.z);
        g3_next.hz  = g2_reg.hz;
    end

    // gain on the radius
    always_comb
    begin
        g4_next.ph  = $signed(g3_reg.r[DW-1:GL]) * rocc_pkg::GAIN_K;
        g4_next.pl  = g3_reg.r[GL-1:0] * rocc_pkg::GAIN_U;
        g4_next.ang = g3_reg.ang;
        g4_next.hz  = g3_reg.hz;
    end

    always_comb
    begin
        sum_r      = (SW'(g4_reg.ph) <<< GL) + $signed(SW'(g4_reg.pl)) + rocc_pkg::GAIN_RND;
        g5_next.gx  = DW'(sum_r >>> 30);
        g5_next.ang = g4_reg.ang;
        g5_next.hz  = g4_reg.hz;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g1_reg <= g1_next;
            g2_reg <= g2_next;
            g3_reg <= g3_next;
            g4_reg <= g4_next;
            g5_reg <= g5_next;
        end
    end

    // ---------------- fold wide angles, rotation ----------------
    rocc_pkg::rot_t rs_reg  [NR+1];
    rocc_pkg::rot_t rs_next [NR+1];

    always_comb
    begin
        rs_next[0].y  = '0;
        rs_next[0].hz = g5_reg.hz;
        if (g5_reg.ang > rocc_pkg::ANG_HALF_PI)
        begin
            rs_next[0].x = -g5_reg.gx;
            rs_next[0].z = g5_reg.ang - rocc_pkg::ANG_PI;
        end
        else if (g5_reg.ang < -rocc_pkg::ANG_HALF_PI)
        begin
            rs_next[0].x = -g5_reg.gx;
            rs_next[0].z = g5_reg.ang + rocc_pkg::ANG_PI;
        end
        else
        begin
            rs_next[0].x = g5_reg.gx;
            rs_next[0].z = g5_reg.ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rs_reg[0] <= rs_next[0];
        end
    end

    genvar j;
    generate
        for (j = 0; j < NR; j++)
        begin : g_rot
            localparam int SH = j;
            always_comb
            begin
                rs_next[j+1].hz = rs_reg[j].hz;
                if (!rs_reg[j].z[AW-1])
                begin
                    rs_next[j+1].x = rs_reg[j].x - (rs_reg[j].y >>> SH);
                    rs_next[j+1].y = rs_reg[j].y + (rs_reg[j].x >>> SH);
                    rs_next[j+1].z = rs_reg[j].z - rocc_pkg::atan_q30(5'(SH));
                end
                else
                begin
                    rs_next[j+1].x = rs_reg[j].x + (rs_reg[j].y >>> SH);
                    rs_next[j+1].y = rs_reg[j].y - (rs_reg[j].x >>> SH);
                    rs_next[j+1].z = rs_reg[j].z + rocc_pkg::atan_q30(5'(SH));
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rs_reg[j+1] <= rs_next[j+1];
                end
            end
        end
    endgenerate

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vv_reg <= '0;
            gv_reg <= '0;
            rv_reg <= '0;
        end
        else if (adv)
        begin
            vv_reg <= {vv_reg[NV-1:0], in_valid};
            gv_reg <= {gv_reg[3:0], vv_reg[NV]};
            rv_reg <= {rv_reg[NR-1:0], gv_reg[4]};
        end
    end

    // ---------------- output register and skid ----------------
    rocc_pkg::res_t res_next;
    rocc_pkg::res_t out_res_reg;
    rocc_pkg::res_t skid_res_reg;
    logic load_from_skid;
    logic load_new_out;
    logic load_new_skid;

    always_comb
    begin
        res_next.x    = rocc_pkg::to_out(rs_reg[NR].x);
        res_next.y    = rocc_pkg::to_out(rs_reg[NR].y);
        res_next.z    = rs_reg[NR].hz;
        load_from_skid = skid_vld_reg & out_take;
        load_new_out   = ~skid_vld_reg & rv_reg[NR] & (~out_vld_reg | out_take);
        load_new_skid  = ~skid_vld_reg & rv_reg[NR] & out_vld_reg & ~out_take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (load_from_skid)
            begin
                skid_vld_reg <= 1'b0;
            end
            else if (load_new_skid)
            begin
                skid_vld_reg <= 1'b1;
            end
            if (load_new_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_take && !skid_vld_reg)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_from_skid)
        begin
            out_res_reg <= skid_res_reg;
        end
        else if (load_new_out)
        begin
            out_res_reg <= res_next;
        end
        if (load_new_skid)
        begin
            skid_res_reg <= res_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_x     = out_res_reg.x;
    assign out_y     = out_res_reg.y;
    assign out_z     = out_res_reg.z;

    // ---------------- assertions ----------------
    `ROCC_ASSERT_IMP(a_skid_behind_out, skid_vld_reg, out_vld_reg, "skid full with output empty")
    `ROCC_ASSERT_NXT(a_skid_drains, skid_vld_reg && out_take, out_vld_reg && !skid_vld_reg, "skid did not move to output")
    `ROCC_ASSERT_NXT(a_skid_fills, !skid_vld_reg && rv_reg[NR] && out_vld_reg && out_stall, skid_vld_reg, "result dropped at full output")

endmodule

// ===== verif/testbench.sv =====
// Testbench of radial_offset_coord_convert_top: random and directed points in both
// coordinate modes, checked against a CORDIC predictor held in a scoreboard class.
// Depends on rocc_pkg and the RTL top level.
module testbench;

    localparam int LATENCY   = 48;
    localparam int N_STAGES  = 20;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint K_Q30       = 64'sd652032874;
    localparam longint CYCLE_LIMIT = 64'd400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] first_coord;
    logic [31:0] second_coord;
    logic [31:0] height;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    radial_offset_coord_convert_top uut (.*);

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } point_t;

    // Predictor of the converter; holds mode and offset and the queue of
    // points still due.
    class point_scoreboard;
        bit          polar;
        longint      offset;
        point_t      due[$];
        int          errors;

        function longint atan_entry(int i);
            longint t;
            t = atan_q30_local(i);
            return t;
        endfunction

        static function longint atan_q30_local(int i);
            longint tab[32] = '{
                64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
                64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
                64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
                64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
                64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
                64'h00000001, 64'h00000000};
            return tab[i];
        endfunction

        function longint gain(longint v);
            return (v * K_Q30 + (64'sd1 <<< 29)) >>> 30;
        endfunction

        function logic [31:0] q16_sat(longint v17);
            longint v;
            v = (v17 + 1) >>> 1;
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            if (v < -64'sd2147483648)
                v = -64'sd2147483648;
            return v[31:0];
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == rocc_pkg::REG_COORD_MODE)
                polar = val[0];
            else if (idx == rocc_pkg::REG_RADIAL_OFFSET)
                offset = longint'($signed(val));
        endfunction

        function void note_input(logic [31:0] a_in, logic [31:0] b_in, logic [31:0] h_in);
            longint a, b, x, y, z, xs, ys, r, m;
            point_t p;
            a = longint'($signed(a_in)) * 2;
            b = longint'($signed(b_in));
            if (!polar) begin
                x = a;
                y = b * 2;
                z = 0;
                if (x == 0 && y == 0) begin
                    r = offset * 2;
                end
                else begin
                    // left half plane: turn by pi first
                    if (x < 0) begin
                        z = (y >= 0) ? PI_Q30 : -PI_Q30;
                        x = -x;
                        y = -y;
                    end
                    for (int i = 0; i < N_STAGES; i++) begin
                        xs = x >>> i;
                        ys = y >>> i;
                        if (y >= 0) begin
                            x += ys; y -= xs; z += atan_entry(i);
                        end
                        else begin
                            x -= ys; y += xs; z -= atan_entry(i);
                        end
                    end
                    r = offset * 2 - gain(x);
                end
            end
            else begin
                m = (b * 16384) % TWO_PI_Q30;
                if (m >= PI_Q30)
                    m -= TWO_PI_Q30;
                if (m < -PI_Q30)
                    m += TWO_PI_Q30;
                z = m;
                r = offset * 2 - a;
            end
            x = gain(r);
            y = 0;
            if (z > HALF_PI_Q30) begin
                x = -x; z -= PI_Q30;
            end
            else if (z < -HALF_PI_Q30) begin
                x = -x; z += PI_Q30;
            end
            for (int i = 0; i < N_STAGES; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= atan_entry(i);
                end
                else begin
                    x += ys; y -= xs; z += atan_entry(i);
                end
            end
            p.x = q16_sat(x);
            p.y = q16_sat(y);
            p.z = h_in;
            due.push_back(p);
        endfunction

        function void check_output(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
            point_t p;
            if (due.size() == 0) begin
                $error("unexpected result transfer x=%h y=%h z=%h", ox, oy, oz);
                errors++;
                return;
            end
            p = due.pop_front();
            if (ox !== p.x) begin
                $error("out_x expected %h actual %h", p.x, ox);
                errors++;
            end
            if (oy !== p.y) begin
                $error("out_y expected %h actual %h", p.y, oy);
                errors++;
            end
            if (oz !== p.z) begin
                $error("out_z expected %h actual %h", p.z, oz);
                errors++;
            end
        endfunction
    endclass

    point_scoreboard sb;
    longint cycles;
    bit     quiet_out;   // phases with no output stalls

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle counter and timeout guard.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[radial_offset_coord_convert_top] ERROR");
            $finish;
        end
    end

    // Result side: check every transfer, stall at random per result.
    initial begin
        int gap;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever begin
            gap = quiet_out ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_output(out_x, out_y, out_z);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    // One input transfer; gap drawn per item, valid dropped only when idling.
    task automatic send_point(logic [31:0] a, logic [31:0] b, logic [31:0] h, bit busy);
        int gap;
        gap = busy ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        first_coord  <= a;
        second_coord <= b;
        height       <= h;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(a, b, h);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
            2: return {{12{1'b0}}, 20'($urandom())} ^ {32{$urandom_range(0, 1) == 1}};
            3: return 32'h80000000 | $urandom_range(0, 3);
            4: return 32'h7FFFFFFF - $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 800000)) - 400000);
        endcase
    endfunction

    // Polar angle: mostly within plus/minus pi, sometimes any value.
    function automatic logic [31:0] rand_angle();
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return 32'($signed($urandom_range(0, 411774)) - 205887);
    endfunction

    initial begin
        logic [31:0] offsets[6] = '{32'h0, 32'h7FFFFFFF, 32'h80000000,
                                    32'h00010000, 32'hFFF00000, 32'h12345678};
        sb = new();
        cycles       = 0;
        quiet_out    = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        first_coord  = '0;
        second_coord = '0;
        height       = '0;
        cfg_we       = 1'b0;
        cfg_index    = rocc_pkg::REG_COORD_MODE;
        cfg_data     = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: origin, half planes, extremes, pass-through of z.
        send_point(32'h0, 32'h0, 32'h80000000, 0);
        send_point(32'hFFFF0000, 32'h0, 32'h7FFFFFFF, 0);
        send_point(32'hFFFF0000, 32'hFFFFFFFF, 32'h0, 0);
        send_point(32'h80000000, 32'h80000000, 32'hFFFFFFFF, 1);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h12345678, 1);
        send_point(32'h80000000, 32'h7FFFFFFF, 32'h1, 0);
        send_point(32'h0, 32'h00010000, 32'h2, 0);
        drain();
        write_reg(rocc_pkg::REG_RADIAL_OFFSET, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h0, 32'h3, 0);
        send_point(32'h0, 32'h0, 32'h4, 0);
        drain();
        write_reg(rocc_pkg::REG_COORD_MODE, 32'hFFFFFFFF);   // only bit 0 counts
        write_reg(rocc_pkg::REG_RADIAL_OFFSET, 32'h80000000);
        // polar: angles at the edges, wide angles, out-of-range angles
        send_point(32'h7FFFFFFF, 32'h0, 32'h5, 0);
        send_point(32'h00010000, 32'h0003243F, 32'h6, 0);
        send_point(32'h00010000, 32'hFFFCDBC1, 32'h7, 1);
        send_point(32'h80000000, 32'h7FFFFFFF, 32'h8, 1);
        send_point(32'h00010000, 32'h80000000, 32'h9, 0);
        send_point(32'h0, 32'h00019220, 32'hA, 0);
        send_point(32'h0, 32'hFFFE6DE0, 32'hB, 0);
        drain();
        write_reg(2'd3, 32'h0);                    // unused index, ignored
        write_reg(rocc_pkg::REG_RADIAL_OFFSET, 32'h00020000);
        send_point(32'h00010000, 32'h00020000, 32'hC, 0);
        drain();

        // Random phases over several settings; some phases run flat out.
        for (int ph = 0; ph < 12; ph++) begin
            drain();
            quiet_out = (ph % 4 == 3);
            write_reg(rocc_pkg::REG_COORD_MODE, {31'($urandom()), ph[0]});
            write_reg(rocc_pkg::REG_RADIAL_OFFSET, (ph < 6) ? offsets[ph] : rand_coord());
            for (int n = 0; n < 170; n++) begin
                if (sb.polar)
                    send_point(rand_coord(), rand_angle(), $urandom(), quiet_out);
                else
                    send_point(rand_coord(), rand_coord(), $urandom(), quiet_out);
                // hold off until the pipe is empty once per phase
                if (n == 80) begin
                    in_valid <= 1'b0;
                    while (sb.due.size() != 0)
                        @(posedge clk);
                end
            end
        end
        quiet_out = 1'b0;
        drain();

        if (sb.errors == 0)
            $display("[radial_offset_coord_convert_top] OK");
        else
            $display("[radial_offset_coord_convert_top] ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/rocc_pkg.sv
rtl/radial_offset_coord_convert_top.sv
verif/testbench.sv
